@@ rtl/core/bfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

	// Operation codes carried on the opcode port
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_RESERVE = 2'd3
	} op_t;

	localparam logic [31:0] RESET_FLOOR = 32'h0010_0000;
	localparam logic [31:0] USABLE_TYPE = 32'd1;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_END,
		ST_BOUND,
		ST_DIV,
		ST_REM,
		ST_WALK,
		ST_RMW,
		ST_SEEK,
		ST_TEST,
		ST_REPORT
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic calc_end;
		logic calc_bound;
		logic calc_div;
		logic calc_rem;
		logic clr_wr;
		logic seek_rd;
		logic seek_take;
		logic seek_skip;
		logic walk_rd;
		logic walk_wr_direct;
		logic walk_wr_rmw;
		logic walk_next;
	} bfa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic alloc_op;
		logic ptr_none;
		logic avail_any;
		logic range_empty;
		logic walk_full;
		logic walk_last;
	} bfa_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/bfa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32768,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/bfa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfa_ctrl
	import bfa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire bfa_stat_t stat,
	output bfa_cmd_t       cmd,
	output logic           busy,
	output logic           done
);

	ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_END;
				end
			end
			ST_END: begin
				if (stat.alloc_op) begin
					state_d = ST_SEEK;
				end else begin
					cmd.calc_end = 1'b1;
					state_d      = ST_BOUND;
				end
			end
			ST_BOUND: begin
				cmd.calc_bound = 1'b1;
				state_d        = ST_DIV;
			end
			ST_DIV: begin
				if (stat.range_empty) begin
					state_d = ST_REPORT;
				end else begin
					cmd.calc_div = 1'b1;
					state_d      = ST_REM;
				end
			end
			ST_REM: begin
				cmd.calc_rem = 1'b1;
				state_d      = ST_WALK;
			end
			ST_WALK: begin
				if (stat.walk_full) begin
					cmd.walk_wr_direct = 1'b1;
					if (stat.walk_last) begin
						state_d = ST_REPORT;
					end else begin
						cmd.walk_next = 1'b1;
					end
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = ST_RMW;
				end
			end
			ST_RMW: begin
				cmd.walk_wr_rmw = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_REPORT;
				end else begin
					cmd.walk_next = 1'b1;
					state_d       = ST_WALK;
				end
			end
			ST_SEEK: begin
				if (stat.ptr_none) begin
					state_d = ST_REPORT;
				end else begin
					cmd.seek_rd = 1'b1;
					state_d     = ST_TEST;
				end
			end
			ST_TEST: begin
				if (stat.avail_any) begin
					cmd.seek_take = 1'b1;
					state_d       = ST_REPORT;
				end else begin
					cmd.seek_skip = 1'b1;
					state_d       = ST_SEEK;
				end
			end
			ST_REPORT: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/bfa_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfa_datapath
	import bfa_pkg::*;
#(
	parameter int NUM_FRAMES    = 1048576,
	parameter int FRAME_SHIFT   = 12,
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bfa_cmd_t    cmd,
	output bfa_stat_t        stat,
	input  wire logic [1:0]  opcode,
	input  wire logic [63:0] address,
	input  wire logic [63:0] length,
	input  wire logic [31:0] region_type,
	input  wire logic        cfg_wr,
	input  wire logic [31:0] cfg_data,
	output logic      [31:0] alloc_addr,
	output logic             found
);

	localparam int W     = MAP_WORD_BITS;
	localparam int DEPTH = (NUM_FRAMES + W - 1) / W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = $clog2(DEPTH + 1);
	localparam int FW    = $clog2(NUM_FRAMES + 1);
	localparam int OW    = $clog2(W);
	localparam int XW    = FW + OW + 1;
	// Word index = frame * RECIP >> K, exact for every frame number below 2^FW
	localparam int K     = FW + 7;
	localparam int RW    = K + 1;
	localparam int PRW   = FW + RW;
	localparam longint unsigned RECIP = ((64'd1 << K) + W - 1) / W;
	localparam logic [RW-1:0]   RECIP_W   = RW'(RECIP);
	localparam logic [63:0]     LOW_MASK  = (64'd1 << FRAME_SHIFT) - 64'd1;
	localparam logic [W-1:0]    ONES      = {W{1'b1}};
	localparam logic [OW-1:0]   TOP_BIT   = OW'(W - 1);
	localparam logic [PW-1:0]   PTR_NONE  = PW'(DEPTH);
	localparam logic [AW-1:0]   LAST_WORD = AW'(DEPTH - 1);

	// Captured item and config
	op_t          op_q;
	logic [63:0]  addr_q;
	logic [63:0]  len_q;
	logic [31:0]  type_q;
	logic [31:0]  floor_q;

	// Range set-up
	logic [63:0]  end_q;
	logic [FW-1:0] lo_q, hi_q;
	logic          empty_q;
	logic [AW-1:0] lo_word_q, last_word_q;
	logic [OW-1:0] lo_off_q, last_off_q;

	// Walk / search position
	logic [AW-1:0] cur_q;
	logic [PW-1:0] ptr_q;

	logic [31:0]   frame_q;
	logic          found_q;

	// Combinational
	logic [63:0]   sum;
	logic [63:0]   a_frame, e_frame, a_up, e_up;
	logic [63:0]   lo_raw, hi_raw;
	logic [FW-1:0] lo_n, hi_n, hm1;
	logic          refused;
	logic [PRW-1:0] prod_lo, prod_last;
	logic [XW-1:0] lo_diff, last_diff;
	logic [OW-1:0] a_off, b_off;
	logic [W-1:0]  mask;
	logic [W-1:0]  rdata, avail, wdata;
	logic [OW-1:0] bit_idx;
	logic [XW-1:0] frame_num;
	logic [63:0]   frame_wide;
	logic          mark;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;

	function automatic logic [FW-1:0] clip_frame(input logic [63:0] v);
		clip_frame = (v > 64'(NUM_FRAMES)) ? FW'(NUM_FRAMES) : v[FW-1:0];
	endfunction

	// Region end, saturating
	assign sum = addr_q + len_q;

	// Frame bounds per operation
	always_comb begin
		a_frame = addr_q >> FRAME_SHIFT;
		e_frame = end_q >> FRAME_SHIFT;
		a_up    = a_frame + 64'(|(addr_q & LOW_MASK));
		e_up    = e_frame + 64'(|(end_q & LOW_MASK));
		case (op_q)
			OP_FREE: begin
				lo_raw = a_frame;
				hi_raw = a_frame + 64'd1;
			end
			OP_RELEASE: begin
				lo_raw = a_up;
				hi_raw = e_frame;
			end
			default: begin
				lo_raw = a_frame;
				hi_raw = e_up;
			end
		endcase
		lo_n    = clip_frame(lo_raw);
		hi_n    = clip_frame(hi_raw);
		refused = (op_q == OP_RELEASE) &&
			((type_q != USABLE_TYPE) || (addr_q < {32'd0, floor_q}));
	end

	// Word index by reciprocal multiply; offsets follow in the next cycle
	assign hm1       = hi_q - FW'(1);
	assign prod_lo   = PRW'(lo_q) * PRW'(RECIP_W);
	assign prod_last = PRW'(hm1) * PRW'(RECIP_W);
	assign lo_diff   = XW'(lo_q) - XW'(lo_word_q) * XW'(W);
	assign last_diff = XW'(hm1) - XW'(last_word_q) * XW'(W);

	// Bit mask of the current word
	always_comb begin
		a_off = (cur_q == lo_word_q) ? lo_off_q : '0;
		b_off = (cur_q == last_word_q) ? last_off_q : TOP_BIT;
		mask  = (ONES << a_off) & (ONES >> (TOP_BIT - b_off));
	end

	// Lowest free bit of the fetched word
	assign avail = ~rdata;
	always_comb begin
		bit_idx = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (avail[i]) begin
				bit_idx = OW'(i);
			end
		end
		frame_num  = XW'(ptr_q[AW-1:0]) * XW'(W) + XW'(bit_idx);
		frame_wide = 64'(frame_num) << FRAME_SHIFT;
	end

	assign mark = (op_q == OP_RESERVE);

	// Memory port steering
	always_comb begin
		ram_we    = cmd.clr_wr | cmd.seek_take | cmd.walk_wr_direct | cmd.walk_wr_rmw;
		ram_waddr = cmd.seek_take ? ptr_q[AW-1:0] : cur_q;
		ram_re    = cmd.seek_rd | cmd.walk_rd;
		ram_raddr = cmd.seek_rd ? ptr_q[AW-1:0] : cur_q;
		if (cmd.clr_wr) begin
			wdata = ONES;
		end else if (cmd.seek_take) begin
			wdata = rdata | (W'(1) << bit_idx);
		end else if (cmd.walk_wr_direct) begin
			wdata = mark ? ONES : '0;
		end else begin
			wdata = mark ? (rdata | mask) : (rdata & ~mask);
		end
	end

	bfa_ram #(
		.WIDTH(W),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// Item capture and range set-up
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(opcode);
			addr_q <= address;
			len_q  <= length;
			type_q <= region_type;
		end
		if (cmd.calc_end) begin
			end_q <= (sum < addr_q) ? '1 : sum;
		end
		if (cmd.calc_bound) begin
			lo_q    <= lo_n;
			hi_q    <= hi_n;
			empty_q <= refused || !(hi_n > lo_n);
		end
		if (cmd.calc_div) begin
			lo_word_q   <= AW'(prod_lo >> K);
			last_word_q <= AW'(prod_last >> K);
		end
		if (cmd.calc_rem) begin
			lo_off_q   <= lo_diff[OW-1:0];
			last_off_q <= last_diff[OW-1:0];
		end
	end

	// Control registers: floor, positions, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= RESET_FLOOR;
			cur_q   <= '0;
			ptr_q   <= PTR_NONE;
			frame_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				floor_q <= cfg_data;
			end
			if (cmd.clr_wr || cmd.walk_next) begin
				cur_q <= cur_q + AW'(1);
			end else if (cmd.calc_rem) begin
				cur_q <= lo_word_q;
			end
			// Every word below ptr_q is full
			if (cmd.seek_skip) begin
				ptr_q <= ptr_q + PW'(1);
			end else if (cmd.calc_rem && !mark && (PW'(lo_word_q) < ptr_q)) begin
				ptr_q <= PW'(lo_word_q);
			end
			if (cmd.load) begin
				frame_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.seek_take) begin
				frame_q <= frame_wide[31:0];
				found_q <= 1'b1;
			end
		end
	end

	always_comb begin
		stat.clear_last  = (cur_q == LAST_WORD);
		stat.alloc_op    = (op_q == OP_ALLOC);
		stat.ptr_none    = (ptr_q == PTR_NONE);
		stat.avail_any   = |avail;
		stat.range_empty = empty_q;
		stat.walk_full   = &mask;
		stat.walk_last   = (cur_q == last_word_q);
	end

	assign alloc_addr = frame_q;
	assign found      = found_q;

endmodule

`default_nettype wire

@@ rtl/core/bitmap_frame_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Transfer when                    Signals
// command    in         start && !busy                   opcode, address, length, region_type
// result     out        done (one cycle, no back-press)  alloc_addr, found
// config     in         cfg_valid && cfg_ready           cfg_data (low_memory_floor)
//
// After reset the map is filled with ones, one word a cycle over all DEPTH words
// (32768 at the default sizes) with busy high; config writes are taken throughout.
// Allocate: reads and then checks map words one at a time, starting from the lowest word
// that may hold a free frame (a read and a check per word of the RAM port); it ends
// without a read, not found, when no word can hold a free frame.
// Free / release / reserve: set up the range, then write each fully covered word
// directly and each partly covered word by read-modify-write on the single map RAM.
// Refused or empty regions skip the walk. The result strobe done cannot be stalled.

module bitmap_frame_allocator
	import bfa_pkg::*;
#(
	parameter int NUM_FRAMES    = 1048576,
	parameter int FRAME_SHIFT   = 12,
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [63:0] address,
	input  wire logic [63:0] length,
	input  wire logic [31:0] region_type,
	output logic             done,
	output logic      [31:0] alloc_addr,
	output logic             found,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	bfa_cmd_t  cmd;
	bfa_stat_t stat;

	assign cfg_ready = 1'b1;

	bfa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	bfa_datapath #(
		.NUM_FRAMES   (NUM_FRAMES),
		.FRAME_SHIFT  (FRAME_SHIFT),
		.MAP_WORD_BITS(MAP_WORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.address      (address),
		.length       (length),
		.region_type  (region_type),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.alloc_addr   (alloc_addr),
		.found        (found)
	);

`ifndef SYNTH
	// Each result is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	// A result only appears while an item is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");

	// An accepted command keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("command accepted but not busy");

	// Allocated addresses are frame aligned
	a_frame_align: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (alloc_addr[FRAME_SHIFT-1:0] == '0))
		else $error("allocated address not frame aligned");
`endif

endmodule

`default_nettype wire
